### design/fccs_pkg.sv
// Shared types and constants for the frame contrast capture selector.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package fccs_pkg;

  // Widths of the state and fields
  localparam int COL_W   = 12;
  localparam int ROW_W   = 11;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 23;
  localparam int SCORE_W = 21;
  localparam int THR_W   = 21;
  localparam int HOLD_W  = 6;
  localparam int CFG_W   = 21;
  localparam int CFG_IDX_W = 2;

  // Sampled rows are multiples of ROW_STEP, from ROW_STEP to SAMPLED_ROWS * ROW_STEP
  localparam int ROW_SHIFT    = 7;
  localparam int ROW_STEP     = 1 << ROW_SHIFT;
  localparam int SAMPLED_ROWS = 7;
  localparam int SAMPLED_LIMIT = SAMPLED_ROWS * ROW_STEP;
  localparam int HOLD_FRAMES  = 60;

  // Operation codes
  localparam logic [1:0] OP_PIXEL     = 2'd0;
  localparam logic [1:0] OP_FRAME_END = 2'd1;
  localparam logic [1:0] OP_RELEASE   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CAM0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CAM1 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ENABLE  = 2'd3;

  // Reset values of the registers
  localparam logic [COL_W-1:0] FRAME_WIDTH_RST = 12'd1280;
  localparam logic [THR_W-1:0] THRESHOLD_RST   = 21'd8000;

  // Target buffer codes
  localparam logic [1:0] TGT_SCRATCH = 2'd0;
  localparam logic [1:0] TGT_CAM0    = 2'd1;
  localparam logic [1:0] TGT_CAM1    = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PIX_W-1:0] pixel;
    logic             release_camera;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               detected;
    logic [1:0]         target_buffer;
    logic               camera_select;
    logic               active_cam;
    logic               capture_restarted;
    logic               ready_cam0;
    logic               ready_cam1;
  } out_word_t;

  // Per-cycle strobes from the input stage to the processing units
  typedef struct packed {
    logic pixel_go;
    logic frame_go;
    logic release_go;
  } strobe_t;

endpackage

`default_nettype wire

### design/fccs_pixel_acc.sv
// Raster position tracking and contrast accumulation over the sampled rows.
// Depends on fccs_pkg.
`default_nettype none

module fccs_pixel_acc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fccs_pkg::strobe_t          strobe,
  input  wire logic [fccs_pkg::PIX_W-1:0] pixel,
  input  wire logic [fccs_pkg::COL_W-1:0] frame_width,
  output logic [fccs_pkg::SUM_W-1:0]      contrast_sum
);

  logic [fccs_pkg::COL_W-1:0] col_r, col_nxt;
  logic [fccs_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [fccs_pkg::PIX_W-1:0] prev_r, prev_nxt;
  logic [fccs_pkg::SUM_W-1:0] sum_r, sum_nxt;

  logic                       sampled;
  logic [fccs_pkg::PIX_W-1:0] diff;
  logic [fccs_pkg::SUM_W:0]   sum_ext;
  logic [fccs_pkg::COL_W-1:0] last_col;

  assign last_col = frame_width - fccs_pkg::COL_W'(1);

  always_comb begin
    sampled = (col_r >= fccs_pkg::COL_W'(2)) && (row_r != '0)
           && (row_r[fccs_pkg::ROW_SHIFT-1:0] == '0)
           && (32'(row_r) <= fccs_pkg::SAMPLED_LIMIT);
    diff    = (pixel > prev_r) ? (pixel - prev_r) : (prev_r - pixel);
    sum_ext = {1'b0, sum_r} + (fccs_pkg::SUM_W+1)'(diff);

    col_nxt  = col_r;
    row_nxt  = row_r;
    prev_nxt = prev_r;
    sum_nxt  = sum_r;
    if (strobe.frame_go) begin
      col_nxt  = '0;
      row_nxt  = '0;
      prev_nxt = '0;
      sum_nxt  = '0;
    end else if (strobe.pixel_go) begin
      prev_nxt = pixel;
      if (sampled) begin
        // saturate at the top of the 23-bit range
        sum_nxt = sum_ext[fccs_pkg::SUM_W] ? '1 : sum_ext[fccs_pkg::SUM_W-1:0];
      end
      if (col_r == last_col) begin
        col_nxt = '0;
        row_nxt = row_r + fccs_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + fccs_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
      sum_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      prev_r <= prev_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign contrast_sum = sum_r;

endmodule

`default_nettype wire

### design/fccs_frame_ctl.sv
// Per-frame detection decision, camera switching and hold countdowns.
// Depends on fccs_pkg; builds the result word for each frame end.
`default_nettype none

module fccs_frame_ctl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fccs_pkg::strobe_t          strobe,
  input  wire logic                       release_camera,
  input  wire logic [fccs_pkg::SUM_W-1:0] contrast_sum,
  input  wire logic [fccs_pkg::THR_W-1:0] threshold_cam0,
  input  wire logic [fccs_pkg::THR_W-1:0] threshold_cam1,
  input  wire logic                       stream_enable,
  output fccs_pkg::out_word_t             result
);

  logic                        cam_r, cam_nxt;
  logic                        ph0_r, ph0_nxt;
  logic                        ph1_r, ph1_nxt;
  logic [fccs_pkg::HOLD_W-1:0] hold0_r, hold0_nxt;
  logic [fccs_pkg::HOLD_W-1:0] hold1_r, hold1_nxt;

  logic [fccs_pkg::SCORE_W-1:0] score;
  logic [fccs_pkg::HOLD_W-1:0]  hold0_dec, hold1_dec, hold_act;
  logic [fccs_pkg::THR_W-1:0]   thr_act;
  logic                         ph_act;
  logic                         detected;
  logic [1:0]                   target;

  assign score = contrast_sum[fccs_pkg::SUM_W-1:2];

  always_comb begin
    hold0_dec = (hold0_r != '0) ? hold0_r - fccs_pkg::HOLD_W'(1) : hold0_r;
    hold1_dec = (hold1_r != '0) ? hold1_r - fccs_pkg::HOLD_W'(1) : hold1_r;
    hold_act  = cam_r ? hold1_dec : hold0_dec;
    thr_act   = cam_r ? threshold_cam1 : threshold_cam0;
    ph_act    = cam_r ? ph1_r : ph0_r;

    cam_nxt   = cam_r;
    ph0_nxt   = ph0_r;
    ph1_nxt   = ph1_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    detected  = 1'b0;
    target    = fccs_pkg::TGT_SCRATCH;

    if (strobe.release_go) begin
      if (release_camera) begin
        hold1_nxt = '0;
      end else begin
        hold0_nxt = '0;
      end
    end else if (strobe.frame_go) begin
      hold0_nxt = hold0_dec;
      hold1_nxt = hold1_dec;
      if (stream_enable) begin
        if (!ph_act) begin
          if (score > thr_act && hold_act == '0) begin
            detected = 1'b1;
            if (cam_r) begin
              ph1_nxt = 1'b1;
              target  = fccs_pkg::TGT_CAM1;
            end else begin
              ph0_nxt = 1'b1;
              target  = fccs_pkg::TGT_CAM0;
            end
          end else begin
            cam_nxt = ~cam_r;
          end
        end else begin
          // frame was held: start its countdown and move on
          if (cam_r) begin
            ph1_nxt   = 1'b0;
            hold1_nxt = fccs_pkg::HOLD_W'(fccs_pkg::HOLD_FRAMES);
          end else begin
            ph0_nxt   = 1'b0;
            hold0_nxt = fccs_pkg::HOLD_W'(fccs_pkg::HOLD_FRAMES);
          end
          cam_nxt = ~cam_r;
        end
      end
    end

    result.score             = score;
    result.detected          = detected;
    result.target_buffer     = target;
    result.camera_select     = cam_nxt;
    result.active_cam        = cam_nxt;
    result.capture_restarted = stream_enable;
    result.ready_cam0        = (hold0_nxt != '0);
    result.ready_cam1        = (hold1_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r   <= 1'b0;
      ph0_r   <= 1'b0;
      ph1_r   <= 1'b0;
      hold0_r <= '0;
      hold1_r <= '0;
    end else begin
      cam_r   <= cam_nxt;
      ph0_r   <= ph0_nxt;
      ph1_r   <= ph1_nxt;
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

endmodule

`default_nettype wire

### design/frame_contrast_capture_selector.sv
// Frame contrast capture selector, top level. Uses fccs_pkg, fccs_pixel_acc, fccs_frame_ctl.
// A frame-end word passes the input register, then the output register, before its result word appears.
// Throughput: one input word per cycle; only a frame end waits, and only while
//   the output register still holds an untaken result.
// Reset (rst_n, synchronous, active low): registers to 1280/8000/8000/0, counters,
//   sum, phases, countdowns cleared, camera 0 active, both stages empty.
`default_nettype none

module frame_contrast_capture_selector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire fccs_pkg::in_word_t             in_data,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output fccs_pkg::out_word_t                 out_data,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [fccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fccs_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [fccs_pkg::COL_W-1:0] frame_width_r;
  logic [fccs_pkg::THR_W-1:0] thr0_r;
  logic [fccs_pkg::THR_W-1:0] thr1_r;
  logic                       stream_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= fccs_pkg::FRAME_WIDTH_RST;
      thr0_r        <= fccs_pkg::THRESHOLD_RST;
      thr1_r        <= fccs_pkg::THRESHOLD_RST;
      stream_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fccs_pkg::REG_FRAME_WIDTH:    frame_width_r <= cfg_wdata[fccs_pkg::COL_W-1:0];
        fccs_pkg::REG_THRESHOLD_CAM0: thr0_r        <= cfg_wdata[fccs_pkg::THR_W-1:0];
        fccs_pkg::REG_THRESHOLD_CAM1: thr1_r        <= cfg_wdata[fccs_pkg::THR_W-1:0];
        fccs_pkg::REG_STREAM_ENABLE:  stream_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register stage. A word leaves it in the cycle it is processed;
  // a frame end leaves only when the output register has room.
  logic               s1_valid_r;
  fccs_pkg::in_word_t s1_word_r;
  logic               out_valid_r;
  fccs_pkg::out_word_t out_word_r;
  logic               out_free;
  logic               s1_is_frame;
  logic               s1_adv;
  fccs_pkg::strobe_t  strobe;
  fccs_pkg::out_word_t result;
  logic [fccs_pkg::SUM_W-1:0] contrast_sum;

  assign out_free    = !out_valid_r || out_ready;
  assign s1_is_frame = (s1_word_r.operation == fccs_pkg::OP_FRAME_END);
  assign s1_adv      = s1_valid_r && (!s1_is_frame || out_free);
  assign in_ready    = !s1_valid_r || s1_adv;

  // Reserved operation code passes through with no strobe.
  assign strobe.pixel_go   = s1_adv && (s1_word_r.operation == fccs_pkg::OP_PIXEL);
  assign strobe.frame_go   = s1_adv && s1_is_frame;
  assign strobe.release_go = s1_adv && (s1_word_r.operation == fccs_pkg::OP_RELEASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
  end

  fccs_pixel_acc u_pixel_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .strobe       (strobe),
    .pixel        (s1_word_r.pixel),
    .frame_width  (frame_width_r),
    .contrast_sum (contrast_sum)
  );

  fccs_frame_ctl u_frame_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .strobe         (strobe),
    .release_camera (s1_word_r.release_camera),
    .contrast_sum   (contrast_sum),
    .threshold_cam0 (thr0_r),
    .threshold_cam1 (thr1_r),
    .stream_enable  (stream_en_r),
    .result         (result)
  );

  // Output register: loaded by a frame end, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (strobe.frame_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (strobe.frame_go) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire
